### src/pfba_pkg.sv
`default_nettype none

package pfba_pkg;

    // Pages held in one bitmap word, and the bits that select a page within it.
    localparam int WORD_PAGES = 32;
    localparam int WORD_LSB   = 5;

    // Memory map type that marks usable memory.
    localparam logic [7:0] USABLE_TYPE = 8'd1;

    // Request codes carried in the kind field.
    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_RESERVE = 2'd1,
        KIND_ALLOC   = 2'd2,
        KIND_FREE    = 2'd3
    } t_kind;

    // Control handed to the word update logic for the word now being read.
    typedef struct packed {
        t_kind                 kind;
        logic [WORD_LSB-1:0]   lo_bit;
        logic [WORD_LSB-1:0]   hi_bit;
        logic                  usable;
    } t_word_ctl;

endpackage

`default_nettype wire

### src/pfba_if.sv
`default_nettype none

// Request channel: one item per allocator request.
interface pfba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] start_address;
    logic [31:0] byte_length;
    logic [31:0] end_address;
    logic [7:0]  region_type;

    modport source (
        output valid, kind, start_address, byte_length, end_address, region_type,
        input  ready
    );
    modport sink (
        input  valid, kind, start_address, byte_length, end_address, region_type,
        output ready
    );
endinterface

// Response channel: one item per request.
interface pfba_rsp_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic [31:0] page_address;

    modport source (
        output valid, granted, page_address,
        input  ready
    );
    modport sink (
        input  valid, granted, page_address,
        output ready
    );
endinterface

`default_nettype wire

### src/pfba_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module pfba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic                                     i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/pfba_word_unit.sv
`default_nettype none

// Read-modify-write logic for one bitmap word.
// Word layout: taken bits in the upper half, present bits in the lower half.
module pfba_word_unit (
    input  wire pfba_pkg::t_word_ctl                         i_ctl,
    input  wire logic [2*pfba_pkg::WORD_PAGES-1:0]           i_rd_data,
    output logic      [2*pfba_pkg::WORD_PAGES-1:0]           o_wr_data,
    output logic                                             o_found,
    output logic      [pfba_pkg::WORD_LSB-1:0]               o_found_bit
);

    localparam int W  = pfba_pkg::WORD_PAGES;
    localparam int LW = pfba_pkg::WORD_LSB;

    logic [W-1:0] w_present;
    logic [W-1:0] w_taken;
    logic [W-1:0] w_mask;
    logic [W-1:0] w_free;
    logic [W-1:0] w_pick;
    logic [W-1:0] w_present_n;
    logic [W-1:0] w_taken_n;

    assign w_present = i_rd_data[W-1:0];
    assign w_taken   = i_rd_data[2*W-1:W];

    // Pages of this word that fall inside the requested range.
    always_comb begin
        for (int j = 0; j < W; j++) begin
            w_mask[j] = (LW'(j) >= i_ctl.lo_bit) && (LW'(j) <= i_ctl.hi_bit);
        end
    end

    // Lowest page that is present and not taken, isolated as a one-hot word.
    assign w_free  = w_present & ~w_taken;
    assign w_pick  = w_free & (~w_free + W'(1));
    assign o_found = |w_free;

    // Encode the one-hot pick into a bit index.
    always_comb begin
        o_found_bit = '0;
        for (int j = 0; j < W; j++) begin
            if (w_pick[j]) begin
                o_found_bit = o_found_bit | LW'(j);
            end
        end
    end

    // Apply the request to the word.
    always_comb begin
        w_present_n = w_present;
        w_taken_n   = w_taken;
        case (i_ctl.kind)
            pfba_pkg::KIND_ADD: begin
                w_present_n = i_ctl.usable ? (w_present | w_mask) : (w_present & ~w_mask);
                w_taken_n   = w_taken & ~w_mask;
            end
            pfba_pkg::KIND_RESERVE: begin
                w_taken_n = w_taken | w_mask;
            end
            pfba_pkg::KIND_ALLOC: begin
                w_taken_n = w_taken | w_pick;
            end
            pfba_pkg::KIND_FREE: begin
                w_taken_n = w_taken & ~w_mask;
            end
            default: begin
                w_taken_n = w_taken;
            end
        endcase
    end

    assign o_wr_data = {w_taken_n, w_present_n};

endmodule

`default_nettype wire

### src/page_frame_bitmap_allocator.sv
// Operation: add region, reserve and free read and rewrite each bitmap word spanned in turn;
// allocate reads words in turn up to the first free page, or up to the last word if none is
// free. Requests outside the table answer the next cycle.
// Throughput: one item at a time; the next item is accepted once the result is taken.
// The rate is set by the bitmap RAM, which is read and written one word per cycle.
// Reset: a clearing pass writes ceil(NUM_PAGES/32) words (2048 by default) before any item.
`default_nettype none

module page_frame_bitmap_allocator #(
    parameter int NUM_PAGES  = 65536,
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfba_req_if.sink   i_req,
    pfba_rsp_if.source o_rsp
);

    localparam int W      = pfba_pkg::WORD_PAGES;
    localparam int LW     = pfba_pkg::WORD_LSB;
    localparam int NWORDS = (NUM_PAGES + W - 1) / W;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PW     = AW + LW;
    localparam int DW     = 2 * W;
    localparam logic [32:0]   PAGES33   = 33'(NUM_PAGES);
    localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN
    } t_state;

    t_state              r_state,      n_state;
    logic [AW-1:0]       r_word,       n_word;
    logic [AW-1:0]       r_first_word, n_first_word;
    logic [AW-1:0]       r_last_word,  n_last_word;
    logic [LW-1:0]       r_first_bit,  n_first_bit;
    logic [LW-1:0]       r_last_bit,   n_last_bit;
    pfba_pkg::t_kind     r_kind,       n_kind;
    logic                r_usable,     n_usable;
    logic                r_out_valid,  n_out_valid;
    logic                r_granted,    n_granted;
    logic [31:0]         r_page_addr,  n_page_addr;

    logic                w_accept;
    logic [32:0]         w_first33;
    logic [32:0]         w_sum33;
    logic [32:0]         w_stop33;
    logic [32:0]         w_stopc33;
    logic [32:0]         w_end33;
    logic [32:0]         w_endc33;
    logic [32:0]         w_last33;
    logic                w_go;
    logic [PW-1:0]       w_first_page;
    logic [PW-1:0]       w_last_page;
    logic [PW-1:0]       w_found_page;
    logic [63:0]         w_found_wide;

    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [DW-1:0]       w_wr_data;
    logic [DW-1:0]       w_rd_data;
    logic [DW-1:0]       w_upd_data;
    logic                w_found;
    logic [LW-1:0]       w_found_bit;
    pfba_pkg::t_word_ctl w_ctl;

    // Handshake: one item at a time, and only once the last result has gone.
    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign w_accept    = i_req.valid && i_req.ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.granted      = r_granted;
    assign o_rsp.page_address = r_page_addr;

    // Page range of the incoming request, clamped to the table.
    assign w_first33 = {1'b0, i_req.start_address} >> PAGE_SHIFT;
    assign w_sum33   = {1'b0, i_req.start_address} + {1'b0, i_req.byte_length};
    assign w_stop33  = w_sum33 >> PAGE_SHIFT;
    assign w_stopc33 = (w_stop33 > PAGES33) ? PAGES33 : w_stop33;
    assign w_end33   = {1'b0, i_req.end_address} >> PAGE_SHIFT;
    assign w_endc33  = (w_end33 >= PAGES33) ? (PAGES33 - 33'd1) : w_end33;

    always_comb begin
        case (pfba_pkg::t_kind'(i_req.kind))
            pfba_pkg::KIND_ADD: begin
                w_go     = w_first33 < w_stopc33;
                w_last33 = w_stopc33 - 33'd1;
            end
            pfba_pkg::KIND_RESERVE: begin
                w_go     = w_first33 <= w_endc33;
                w_last33 = w_endc33;
            end
            pfba_pkg::KIND_ALLOC: begin
                w_go     = 1'b1;
                w_last33 = w_first33;
            end
            default: begin
                w_go     = w_first33 < PAGES33;
                w_last33 = w_first33;
            end
        endcase
    end

    assign w_first_page = w_first33[PW-1:0];
    assign w_last_page  = w_last33[PW-1:0];

    // Control for the word whose read data is arriving this cycle.
    assign w_ctl.kind   = r_kind;
    assign w_ctl.lo_bit = (r_word == r_first_word) ? r_first_bit : '0;
    assign w_ctl.hi_bit = (r_word == r_last_word) ? r_last_bit : '1;
    assign w_ctl.usable = r_usable;

    // Byte address of the page found by an allocate.
    assign w_found_page = {r_word, w_found_bit};
    assign w_found_wide = 64'(w_found_page) << PAGE_SHIFT;

    // Sequencer: clearing pass, then request handling one word per cycle.
    always_comb begin
        n_state      = r_state;
        n_word       = r_word;
        n_first_word = r_first_word;
        n_last_word  = r_last_word;
        n_first_bit  = r_first_bit;
        n_last_bit   = r_last_bit;
        n_kind       = r_kind;
        n_usable     = r_usable;
        n_out_valid  = r_out_valid;
        n_granted    = r_granted;
        n_page_addr  = r_page_addr;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_word + AW'(1);
        w_wr_en      = 1'b0;
        w_wr_addr    = r_word;
        w_wr_data    = w_upd_data;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_data = '0;
                n_word    = r_word + AW'(1);
                if (r_word == LAST_WORD) begin
                    n_word  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_kind   = pfba_pkg::t_kind'(i_req.kind);
                    n_usable = (i_req.region_type == pfba_pkg::USABLE_TYPE);
                    if (pfba_pkg::t_kind'(i_req.kind) == pfba_pkg::KIND_ALLOC) begin
                        n_first_word = '0;
                        n_last_word  = LAST_WORD;
                        n_first_bit  = '0;
                        n_last_bit   = '1;
                    end else begin
                        n_first_word = w_first_page[PW-1:LW];
                        n_last_word  = w_last_page[PW-1:LW];
                        n_first_bit  = w_first_page[LW-1:0];
                        n_last_bit   = w_last_page[LW-1:0];
                    end
                    if (w_go) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = n_first_word;
                        n_word    = n_first_word;
                        n_state   = S_RUN;
                    end else begin
                        n_out_valid = 1'b1;
                        n_granted   = 1'b0;
                        n_page_addr = '0;
                    end
                end
            end
            S_RUN: begin
                if (r_kind == pfba_pkg::KIND_ALLOC) begin
                    w_wr_en = w_found;
                    if (w_found) begin
                        n_out_valid = 1'b1;
                        n_granted   = 1'b1;
                        n_page_addr = w_found_wide[31:0];
                        n_state     = S_IDLE;
                    end else if (r_word == r_last_word) begin
                        n_out_valid = 1'b1;
                        n_granted   = 1'b0;
                        n_page_addr = '0;
                        n_state     = S_IDLE;
                    end else begin
                        w_rd_en = 1'b1;
                        n_word  = r_word + AW'(1);
                    end
                end else begin
                    w_wr_en = 1'b1;
                    if (r_word == r_last_word) begin
                        n_out_valid = 1'b1;
                        n_granted   = 1'b0;
                        n_page_addr = '0;
                        n_state     = S_IDLE;
                    end else begin
                        w_rd_en = 1'b1;
                        n_word  = r_word + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
        r_first_word <= n_first_word;
        r_last_word  <= n_last_word;
        r_first_bit  <= n_first_bit;
        r_last_bit   <= n_last_bit;
        r_kind       <= n_kind;
        r_usable     <= n_usable;
        r_granted    <= n_granted;
        r_page_addr  <= n_page_addr;
    end

    // Bitmap store: present and taken bits for one word of pages per entry.
    pfba_ram #(
        .WIDTH (DW),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Word update and first-fit search.
    pfba_word_unit u_word (
        .i_ctl       (w_ctl),
        .i_rd_data   (w_rd_data),
        .o_wr_data   (w_upd_data),
        .o_found     (w_found),
        .o_found_bit (w_found_bit)
    );

endmodule

`default_nettype wire

### src/pfba_checker.sv
`default_nettype none

module pfba_checker #(
    parameter int PAGE_SHIFT = 12
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic [1:0]  i_req_kind,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic        i_rsp_granted,
    input wire logic [31:0] i_rsp_page_address
);

    logic r_busy;
    logic r_alloc;

    // Track the item in flight and whether it is an allocate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_alloc <= 1'b0;
        end else begin
            if (i_req_valid && i_req_ready) begin
                r_busy  <= 1'b1;
                r_alloc <= (pfba_pkg::t_kind'(i_req_kind) == pfba_pkg::KIND_ALLOC);
            end else if (i_rsp_valid && i_rsp_ready) begin
                r_busy <= 1'b0;
            end
        end
    end

    // A new item is taken only once the previous result has been delivered.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |-> !r_busy)
        else $error("item accepted while another is still in flight");

    // Every result belongs to an accepted item.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_busy)
        else $error("result shown with no item in flight");

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_granted) && $stable(i_rsp_page_address)))
        else $error("result changed while stalled");

    // A refused or non-allocate result carries address zero.
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_granted) |-> (i_rsp_page_address == 32'd0))
        else $error("non-zero address without a grant");

    // Only an allocate is granted, and its address is page aligned.
    a_grant_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_granted) |->
            (r_alloc && (i_rsp_page_address[PAGE_SHIFT-1:0] == '0)))
        else $error("grant on a non-allocate item or unaligned page address");

endmodule

bind page_frame_bitmap_allocator pfba_checker #(
    .PAGE_SHIFT (PAGE_SHIFT)
) u_pfba_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_req_kind         (i_req.kind),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_granted      (o_rsp.granted),
    .i_rsp_page_address (o_rsp.page_address)
);

`default_nettype wire

### verif/tb_page_frame_bitmap_allocator.sv
module tb_page_frame_bitmap_allocator;

    localparam int unsigned TABLE_PAGES  = 65536;
    localparam int unsigned PAGE_BITS    = 12;
    localparam int          NUM_DIRECTED = 26;
    localparam int          RANDOM_ITEMS = 450;
    localparam int          DRAIN_AT     = 80;
    localparam int          CALM_FROM    = 150;
    localparam int          CALM_TO      = 230;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          QUIET_LIMIT  = 20000;
    localparam int          SETTLE_WAIT  = 60;
    localparam int          MAX_REPORTS  = 10;
    localparam int          BREAK_PCT    = 16;

    // One request item, with the answer typed in for rows where it is obvious.
    typedef struct packed {
        pfba_pkg::t_kind kind;
        logic [31:0]     start_address;
        logic [31:0]     byte_length;
        logic [31:0]     end_address;
        logic [7:0]      region_type;
        logic            pinned;
        logic            exp_granted;
        logic [31:0]     exp_address;
    } t_frame_req;

    typedef struct packed {
        logic        granted;
        logic [31:0] page_address;
    } t_grant;

    // Directed requests: reset state, first fit, reserve and free corners,
    // region sums beyond 32 bits and pages beyond the table.
    localparam t_frame_req DIRECTED [NUM_DIRECTED] = '{
        '{pfba_pkg::KIND_ALLOC,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ADD,     32'h0000_0000, 32'h0000_8000, 32'h0000_0000, 8'h01,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ALLOC,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b1, 32'h0},
        '{pfba_pkg::KIND_ALLOC,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b1, 32'h0000_1000},
        '{pfba_pkg::KIND_RESERVE, 32'h0000_2000, 32'h0000_0000, 32'h0000_3FFF, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ALLOC,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b1, 32'h0000_4000},
        '{pfba_pkg::KIND_FREE,    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ALLOC,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b1, 32'h0},
        '{pfba_pkg::KIND_FREE,    32'h0000_5123, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_RESERVE, 32'h0000_7000, 32'h0000_0000, 32'h0000_6000, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ALLOC,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b1, 32'h0000_5000},
        '{pfba_pkg::KIND_ADD,     32'h0000_6000, 32'h0000_1000, 32'h0000_0000, 8'hFF,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ALLOC,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b1, 32'h0000_7000},
        '{pfba_pkg::KIND_ALLOC,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ADD,     32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0000_0000, 8'h01,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ADD,     32'h0000_9000, 32'h0000_0000, 32'h0000_0000, 8'h01,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ADD,     32'h0FFF_F000, 32'h0000_2000, 32'h0000_0000, 8'h01,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ALLOC,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b1, 32'h0FFF_F000},
        '{pfba_pkg::KIND_FREE,    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_RESERVE, 32'h1000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_FREE,    32'h0FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_RESERVE, 32'h0FFF_0000, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ALLOC,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ADD,     32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 8'h01,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ADD,     32'h0000_0FFF, 32'h0000_1001, 32'h0000_0000, 8'h00,
          1'b1, 1'b0, 32'h0},
        '{pfba_pkg::KIND_ALLOC,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00,
          1'b1, 1'b1, 32'h0000_2000}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pfba_req_if req_ch ();
    pfba_rsp_if rsp_ch ();

    page_frame_bitmap_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Typed-in answer travelling alongside the request item on offer.
    logic        req_pinned;
    logic        req_exp_granted;
    logic [31:0] req_exp_address;

    // Shadow bitmap of the allocator.
    bit page_present [TABLE_PAGES];
    bit page_taken   [TABLE_PAGES];

    t_grant pending_grants [$];
    int     failures      = 0;
    int     items_sent    = 0;
    int     results_seen  = 0;
    int     quiet_cycles  = 0;
    bit     calm          = 1'b0;
    bit     stall_results = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic record_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < BREAK_PCT);
    endfunction

    // Applies one request to the shadow bitmap and returns the grant it yields.
    function automatic t_grant apply_request(input t_frame_req r);
        t_grant      g;
        logic [32:0] end_sum;
        int unsigned first_page;
        int unsigned stop_page;
        int unsigned p;
        bit          found;
        g          = '0;
        first_page = r.start_address >> PAGE_BITS;
        case (r.kind)
            pfba_pkg::KIND_ADD: begin
                // The region end is summed at 33 bits and is exclusive.
                end_sum   = {1'b0, r.start_address} + {1'b0, r.byte_length};
                stop_page = 32'(end_sum >> PAGE_BITS);
                if (stop_page > TABLE_PAGES) begin
                    stop_page = TABLE_PAGES;
                end
                for (p = first_page; p < stop_page; p++) begin
                    page_present[p] = (r.region_type == pfba_pkg::USABLE_TYPE);
                    page_taken[p]   = 1'b0;
                end
            end
            pfba_pkg::KIND_RESERVE: begin
                // Both ends included; the last page is clipped to the table.
                stop_page = r.end_address >> PAGE_BITS;
                if (stop_page >= TABLE_PAGES) begin
                    stop_page = TABLE_PAGES - 1;
                end
                for (p = first_page; p <= stop_page; p++) begin
                    page_taken[p] = 1'b1;
                end
            end
            pfba_pkg::KIND_ALLOC: begin
                // First fit: the lowest page that is present and not taken.
                found = 1'b0;
                p     = 0;
                while (!found && p < TABLE_PAGES) begin
                    if (page_present[p] && !page_taken[p]) begin
                        page_taken[p]  = 1'b1;
                        g.granted      = 1'b1;
                        g.page_address = p << PAGE_BITS;
                        found          = 1'b1;
                    end
                    p++;
                end
            end
            default: begin
                if (first_page < TABLE_PAGES) begin
                    page_taken[first_page] = 1'b0;
                end
            end
        endcase
        return g;
    endfunction

    // Addresses lean towards the bottom of the table, where allocation happens.
    function automatic logic [31:0] pick_address();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(0, 32'h0003_FFFF);
        end else if (roll < 85) begin
            return $urandom_range(0, 32'h0FFF_FFFF);
        end else if (roll < 95) begin
            return $urandom();
        end
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0FFF_F000;
            default: return 32'h1000_0000;
        endcase
    endfunction

    function automatic t_frame_req random_request();
        t_frame_req  r;
        int unsigned roll;
        r               = '0;
        r.start_address = pick_address();
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            r.kind = pfba_pkg::KIND_ALLOC;
        end else if (roll < 65) begin
            r.kind = pfba_pkg::KIND_FREE;
        end else if (roll < 85) begin
            r.kind = pfba_pkg::KIND_ADD;
        end else begin
            r.kind = pfba_pkg::KIND_RESERVE;
        end
        // Mostly short regions; a few long ones sweep the whole table.
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            r.byte_length = $urandom_range(0, 32'h0001_0000);
        end else if (roll < 95) begin
            r.byte_length = $urandom_range(0, 32'h0040_0000);
        end else begin
            r.byte_length = $urandom();
        end
        if ($urandom_range(0, 99) < 95) begin
            r.end_address = r.start_address + $urandom_range(0, 32'h0000_8000);
        end else begin
            r.end_address = $urandom();
        end
        if ($urandom_range(0, 99) < 75) begin
            r.region_type = pfba_pkg::USABLE_TYPE;
        end else begin
            r.region_type = 8'($urandom_range(0, 255));
        end
        return r;
    endfunction

    // Offers one item and holds it until the allocator takes it.
    task automatic offer_request(input t_frame_req r);
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= r.kind;
        req_ch.start_address <= r.start_address;
        req_ch.byte_length   <= r.byte_length;
        req_ch.end_address   <= r.end_address;
        req_ch.region_type   <= r.region_type;
        req_pinned           <= r.pinned;
        req_exp_granted      <= r.exp_granted;
        req_exp_address      <= r.exp_address;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic pause_sender();
        while (take_break()) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Request side: reset, directed table, then random traffic.
    initial begin
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.kind          <= pfba_pkg::KIND_ADD;
        req_ch.start_address <= '0;
        req_ch.byte_length   <= '0;
        req_ch.end_address   <= '0;
        req_ch.region_type   <= '0;
        req_pinned           <= 1'b0;
        req_exp_granted      <= 1'b0;
        req_exp_address      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < NUM_DIRECTED; n++) begin
            pause_sender();
            offer_request(DIRECTED[n]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= CALM_FROM && n < CALM_TO);
            if (n == DRAIN_AT) begin
                // Let every outstanding result come back before going on.
                req_ch.valid <= 1'b0;
                while (results_seen < items_sent) @(posedge i_clk);
            end
            if (n == HOLD_AT) begin
                stall_results = 1'b1;
            end
            pause_sender();
            offer_request(random_request());
        end

        req_ch.valid <= 1'b0;
        while (results_seen < items_sent) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (pending_grants.size() != 0) begin
            record_failure($sformatf("%0d results never arrived", pending_grants.size()));
        end
        if (failures == 0) begin
            $display("** page_frame_bitmap_allocator: PASSED **");
        end else begin
            $display("** page_frame_bitmap_allocator: FAILED **");
        end
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_results) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                stall_results = 1'b0;
            end else begin
                rsp_ch.ready <= !take_break();
            end
        end
    end

    // Predict on every accepted request; compare every accepted result.
    always @(posedge i_clk) begin
        t_frame_req seen_req;
        t_grant     want;
        if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            seen_req               = '0;
            seen_req.kind          = pfba_pkg::t_kind'(req_ch.kind);
            seen_req.start_address = req_ch.start_address;
            seen_req.byte_length   = req_ch.byte_length;
            seen_req.end_address   = req_ch.end_address;
            seen_req.region_type   = req_ch.region_type;
            want = apply_request(seen_req);
            if (req_pinned) begin
                want = '{req_exp_granted, req_exp_address};
            end
            pending_grants.push_back(want);
        end
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            results_seen++;
            if (pending_grants.size() == 0) begin
                record_failure("result arrived with no request outstanding");
            end else begin
                want = pending_grants.pop_front();
                if (rsp_ch.granted !== want.granted) begin
                    record_failure($sformatf("result %0d granted: expected %0b, got %0b",
                                             results_seen, want.granted, rsp_ch.granted));
                end
                if (rsp_ch.page_address !== want.page_address) begin
                    record_failure($sformatf("result %0d page_address: expected %h, got %h",
                                             results_seen, want.page_address,
                                             rsp_ch.page_address));
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either channel.
    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no item moved for %0d cycles", $realtime, quiet_cycles);
            $display("** page_frame_bitmap_allocator: FAILED **");
            $finish;
        end
    end

endmodule
